// File: hw/rtl/spa_pkg.sv
// Shared types, operation codes and default sizes for the slot pool allocator.
package spa_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CAP_BITS       = 11;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(1024);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_CHECK  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [9:0]  slot_index;
        logic [31:0] store_value;
    } t_req;

    typedef struct packed {
        logic [9:0]          handle;
        logic [31:0]         read_value;
        logic                live;
        logic                full_res;
        logic [CAP_BITS-1:0] live_count;
    } t_res;

    typedef struct packed {
        logic capture;
        logic exec;
        logic cfg_we;
    } t_ctl_cmd;

endpackage

// File: hw/rtl/spa_ctrl.sv
// Controller state machine that sequences each request through read and update.
module spa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_cfg_valid,
    output logic              busy,
    output logic              o_cfg_ready,
    output logic              o_res_strobe,
    output spa_pkg::t_ctl_cmd o_cmd
);
    import spa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_EXEC);
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign o_res_strobe  = r_strobe;
    assign o_cmd.capture = start && (r_state == S_IDLE);
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.cfg_we  = i_cfg_valid && (r_state == S_IDLE);

endmodule

// File: hw/rtl/spa_datapath.sv
// Datapath holding the slot memory, the free list registers and the result register.
module spa_datapath #(
    parameter int SLOTS      = spa_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = spa_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spa_pkg::t_ctl_cmd             i_cmd,
    input  spa_pkg::t_req                 i_req,
    input  logic [spa_pkg::CAP_BITS-1:0]  i_cfg_data,
    output spa_pkg::t_res                 o_res
);
    import spa_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam int WW = (VALUE_BITS > CW) ? VALUE_BITS : CW;

    localparam logic [MW-1:0] SLOTS_W = MW'(SLOTS);

    logic [WW:0]         mem [SLOTS];
    logic [WW:0]         r_rd_word;
    logic [IW-1:0]       rd_addr;

    logic [CAP_BITS-1:0] r_cap;
    logic [CW-1:0]       r_fh;
    logic [CW-1:0]       n_fh;
    logic [CW-1:0]       r_hw;
    logic [CW-1:0]       n_hw;
    logic [CW-1:0]       r_live;
    logic [CW-1:0]       n_live;
    t_req                r_req;
    t_res                r_res;
    t_res                n_res;

    logic                we;
    logic [IW-1:0]       wr_addr;
    logic [WW:0]         wr_word;

    logic [MW-1:0]       in_idx_ext;
    logic [MW-1:0]       fh_ext;
    logic [MW-1:0]       hw_ext;
    logic [MW-1:0]       idx_ext;
    logic [MW-1:0]       cap_ext;
    logic [MW-1:0]       eff_cap;
    logic [MW-1:0]       live_ext;
    logic                slot_hit;
    logic [63:0]         val_ext;
    logic [63:0]         rd_val_ext;

    assign in_idx_ext = MW'(i_req.slot_index);
    assign fh_ext     = MW'(r_fh);
    assign hw_ext     = MW'(r_hw);
    assign idx_ext    = MW'(r_req.slot_index);
    assign cap_ext    = MW'(r_cap);
    assign eff_cap    = (cap_ext > SLOTS_W) ? SLOTS_W : cap_ext;
    assign slot_hit   = (idx_ext < hw_ext) && (idx_ext < SLOTS_W) && !r_rd_word[WW];
    assign val_ext    = 64'(r_req.store_value);
    assign rd_val_ext = 64'(r_rd_word[VALUE_BITS-1:0]);

    assign rd_addr = (i_req.operation == OP_ADD) ? fh_ext[IW-1:0] : in_idx_ext[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_word <= mem[rd_addr];
        end
        if (we) begin
            mem[wr_addr] <= wr_word;
        end
    end

    always_comb begin
        n_fh     = r_fh;
        n_hw     = r_hw;
        n_live   = r_live;
        we       = 1'b0;
        wr_addr  = fh_ext[IW-1:0];
        wr_word  = {1'b0, WW'(val_ext[VALUE_BITS-1:0])};
        n_res    = '0;
        case (r_req.operation)
            OP_ADD: begin
                if (fh_ext >= eff_cap) begin
                    n_res.full_res = 1'b1;
                end else begin
                    if (r_fh == r_hw) begin
                        n_fh = r_fh + CW'(1);
                        n_hw = r_hw + CW'(1);
                    end else begin
                        n_fh = r_rd_word[CW-1:0];
                    end
                    we           = 1'b1;
                    n_live       = r_live + CW'(1);
                    n_res.handle = fh_ext[9:0];
                end
            end
            OP_REMOVE: begin
                if (slot_hit) begin
                    we      = 1'b1;
                    wr_addr = idx_ext[IW-1:0];
                    wr_word = {1'b1, WW'(r_fh)};
                    n_fh    = idx_ext[CW-1:0];
                    n_live  = r_live - CW'(1);
                end
            end
            OP_GET: begin
                if (slot_hit) begin
                    n_res.live       = 1'b1;
                    n_res.read_value = rd_val_ext[31:0];
                end
            end
            OP_CHECK: begin
                n_res.live = slot_hit;
            end
            OP_CLEAR: begin
                n_fh   = '0;
                n_hw   = '0;
                n_live = '0;
            end
            default: begin
            end
        endcase
        we               = we && i_cmd.exec;
        live_ext         = MW'(n_live);
        n_res.live_count = live_ext[CAP_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_fh   <= '0;
            r_hw   <= '0;
            r_live <= '0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_fh   <= n_fh;
                r_hw   <= n_hw;
                r_live <= n_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

    a_live_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_hw)
        else $error("live count exceeds high-water mark");

    a_fh_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fh <= r_hw)
        else $error("free head beyond high-water mark");

    a_hw_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        MW'(r_hw) <= SLOTS_W)
        else $error("high-water mark beyond slot count");

    a_full_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && n_res.full_res |=> $stable(r_fh) && $stable(r_live))
        else $error("refused add changed pool state");

endmodule

// File: hw/rtl/slot_pool_allocator.sv
// Top level of the slot pool allocator: controller and datapath.
// One request is taken when start is high and busy is low; busy then stays high for one cycle
// and the result shows on o_res with o_res_strobe high for exactly one cycle, the cycle after
// the busy cycle, and is taken at the second rising edge after the transfer. A new request
// may be taken in the cycle the result shows, so the pool sustains one request every two
// cycles, set by the synchronous read of the slot memory that must land before the free list
// and the slot are updated. The receiver cannot stall: a result must be taken in the cycle
// its strobe is high. The capacity register is written over the cfg channel while the block
// is idle. There is no clearing pass after reset.
module slot_pool_allocator #(
    parameter int SLOTS      = spa_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = spa_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  spa_pkg::t_req                i_req,
    output spa_pkg::t_res                o_res,
    output logic                         o_res_strobe,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [spa_pkg::CAP_BITS-1:0] i_cfg_data
);
    import spa_pkg::*;

    t_ctl_cmd cmd;

    spa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_cfg_valid  (i_cfg_valid),
        .busy         (busy),
        .o_cfg_ready  (o_cfg_ready),
        .o_res_strobe (o_res_strobe),
        .o_cmd        (cmd)
    );

    spa_datapath #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (i_req),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_res)
    );

endmodule
